>>> src/uart_tx_buffered_bitbang_macros.svh
// Assertion macros shared by the UART transmitter modules.
`ifndef UART_TX_BUFFERED_BITBANG_MACROS_SVH
`define UART_TX_BUFFERED_BITBANG_MACROS_SVH

// Property holds at every clock edge outside reset.
`define UTXBB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent holds in the same cycle as the trigger.
`define UTXBB_ASSERT_SAME(label, trig, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (conseq)) \
      else $error(msg);

// Consequent holds in the cycle after the trigger.
`define UTXBB_ASSERT_NEXT(label, trig, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (conseq)) \
      else $error(msg);

`endif

>>> src/utxbb_pkg.sv
// Types and constants of the buffered UART transmitter.
package utxbb_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int DATA_BITS    = 8;
   localparam int BYTE_W       = 8;
   localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int BIT_W        = $clog2(DATA_BITS);

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BUSY = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      TX_IDLE,
      TX_START,
      TX_DATA,
      TX_STOP,
      TX_GAP
   } tx_state_type;

   typedef enum logic [1:0] {
      LINE_LOW,
      LINE_HIGH,
      LINE_DATA
   } line_src_type;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic       tx_line;
      logic       busy_res;
      status_type status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic         out_load;
      logic         wr_en;
      logic         len_clear;
      logic         rd_en;
      logic         read_inc;
      logic         bit_clear;
      logic         bit_inc;
      logic         line_we;
      line_src_type line_src;
      status_type   status;
      logic         busy;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic buf_full;
      logic last_bit;
      logic last_byte_sent;
   } dp_stat_type;

endpackage

>>> src/utxbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module utxbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/utxbb_ctrl.sv
// Frame sequencer and beat handshake control.
`include "uart_tx_buffered_bitbang_macros.svh"

module utxbb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  utxbb_pkg::dp_stat_type stat,
   output utxbb_pkg::dp_cmd_type  cmd
);

   utxbb_pkg::tx_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= utxbb_pkg::TX_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.out_load  = accept;
      cmd.wr_en     = 1'b0;
      cmd.len_clear = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.read_inc  = 1'b0;
      cmd.bit_clear = 1'b0;
      cmd.bit_inc   = 1'b0;
      cmd.line_we   = 1'b0;
      cmd.line_src  = utxbb_pkg::LINE_HIGH;
      cmd.status    = utxbb_pkg::STATUS_OK;
      if (accept) begin
         if (req_mode) begin
            unique case (state_ff)
               utxbb_pkg::TX_IDLE: begin
                  state_in = utxbb_pkg::TX_IDLE;
               end
               utxbb_pkg::TX_START: begin
                  // fetch this byte; data is ready for the next tick
                  cmd.line_we   = 1'b1;
                  cmd.line_src  = utxbb_pkg::LINE_LOW;
                  cmd.bit_clear = 1'b1;
                  cmd.rd_en     = 1'b1;
                  state_in      = utxbb_pkg::TX_DATA;
               end
               utxbb_pkg::TX_DATA: begin
                  cmd.line_we  = 1'b1;
                  cmd.line_src = utxbb_pkg::LINE_DATA;
                  cmd.bit_inc  = 1'b1;
                  if (stat.last_bit) begin
                     state_in = utxbb_pkg::TX_STOP;
                  end
               end
               utxbb_pkg::TX_STOP: begin
                  cmd.line_we  = 1'b1;
                  cmd.line_src = utxbb_pkg::LINE_HIGH;
                  state_in     = utxbb_pkg::TX_GAP;
               end
               utxbb_pkg::TX_GAP: begin
                  if (stat.last_byte_sent) begin
                     cmd.len_clear = 1'b1;
                     state_in      = utxbb_pkg::TX_IDLE;
                  end else begin
                     cmd.read_inc = 1'b1;
                     state_in     = utxbb_pkg::TX_START;
                  end
               end
               default: begin
                  state_in = utxbb_pkg::TX_IDLE;
               end
            endcase
         end else if (state_ff != utxbb_pkg::TX_IDLE) begin
            cmd.status = utxbb_pkg::STATUS_BUSY;
         end else begin
            if (stat.buf_full) begin
               cmd.status = utxbb_pkg::STATUS_FULL;
            end else begin
               cmd.wr_en = 1'b1;
            end
            // buffer is never empty after a load, so last always starts
            if (req_last) begin
               state_in = utxbb_pkg::TX_START;
            end
         end
      end
      cmd.busy = (state_in != utxbb_pkg::TX_IDLE);
   end

   `UTXBB_ASSERT_SAME(a_wr_only_idle, cmd.wr_en, state_ff == utxbb_pkg::TX_IDLE, "load while busy")
   `UTXBB_ASSERT_NEXT(a_start_to_data, accept && req_mode && state_ff == utxbb_pkg::TX_START, state_ff == utxbb_pkg::TX_DATA, "start bit not followed by data")
   `UTXBB_ASSERT_SAME(a_stall_holds, rsp_valid_ff && !rsp_ready, !accept, "beat taken over a held result")

endmodule

>>> src/utxbb_dpath.sv
// Byte buffer, counters, line level and result register.
`include "uart_tx_buffered_bitbang_macros.svh"

module utxbb_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [utxbb_pkg::BYTE_W-1:0]     req_byte,
   input  utxbb_pkg::dp_cmd_type            cmd,
   output utxbb_pkg::dp_stat_type           stat,
   output utxbb_pkg::rsp_type               rsp_data
);

   logic                           line_ff, line_in;
   logic [utxbb_pkg::BIT_W-1:0]    bit_pos_ff, bit_pos_in;
   logic [utxbb_pkg::ADDR_W-1:0]   read_pos_ff, read_pos_in;
   logic [utxbb_pkg::LEN_W-1:0]    msg_len_ff, msg_len_in;
   utxbb_pkg::rsp_type             rsp_data_ff;
   logic [utxbb_pkg::BYTE_W-1:0]   rd_data;
   logic [utxbb_pkg::LEN_W:0]      read_next;

   utxbb_ram #(
      .WIDTH (utxbb_pkg::BYTE_W),
      .DEPTH (utxbb_pkg::BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (msg_len_ff[utxbb_pkg::ADDR_W-1:0]),
      .wr_data (req_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (read_pos_ff),
      .rd_data (rd_data)
   );

   assign read_next = {1'b0, utxbb_pkg::LEN_W'(read_pos_ff)} + 1'b1;

   assign stat.buf_full       = (msg_len_ff == utxbb_pkg::LEN_W'(utxbb_pkg::BUFFER_DEPTH));
   assign stat.last_bit       = (bit_pos_ff == utxbb_pkg::BIT_W'(utxbb_pkg::DATA_BITS - 1));
   assign stat.last_byte_sent = (read_next >= {1'b0, msg_len_ff});

   always_comb begin
      line_in = line_ff;
      if (cmd.line_we) begin
         unique case (cmd.line_src)
            utxbb_pkg::LINE_LOW:  line_in = 1'b0;
            utxbb_pkg::LINE_HIGH: line_in = 1'b1;
            utxbb_pkg::LINE_DATA: line_in = rd_data[bit_pos_ff];
            default:              line_in = 1'b1;
         endcase
      end

      bit_pos_in = bit_pos_ff;
      if (cmd.bit_clear) begin
         bit_pos_in = '0;
      end else if (cmd.bit_inc) begin
         bit_pos_in = bit_pos_ff + 1'b1;
      end

      read_pos_in = read_pos_ff;
      msg_len_in  = msg_len_ff;
      if (cmd.len_clear) begin
         read_pos_in = '0;
         msg_len_in  = '0;
      end else begin
         if (cmd.read_inc) begin
            read_pos_in = read_pos_ff + 1'b1;
         end
         if (cmd.wr_en) begin
            msg_len_in = msg_len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= 1'b1;
         bit_pos_ff  <= '0;
         read_pos_ff <= '0;
         msg_len_ff  <= '0;
      end else begin
         line_ff     <= line_in;
         bit_pos_ff  <= bit_pos_in;
         read_pos_ff <= read_pos_in;
         msg_len_ff  <= msg_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.tx_line  <= line_in;
         rsp_data_ff.busy_res <= cmd.busy;
         rsp_data_ff.status   <= cmd.status;
      end
   end

   assign rsp_data = rsp_data_ff;

   `UTXBB_ASSERT_ALWAYS(a_len_bound, msg_len_ff <= utxbb_pkg::LEN_W'(utxbb_pkg::BUFFER_DEPTH), "length past depth")
   `UTXBB_ASSERT_SAME(a_read_in_msg, cmd.rd_en, {1'b0, utxbb_pkg::LEN_W'(read_pos_ff)} < {1'b0, msg_len_ff}, "read past message")
   `UTXBB_ASSERT_NEXT(a_len_grows, cmd.wr_en, msg_len_ff == $past(msg_len_ff) + 1'b1, "length not advanced on load")

endmodule

>>> src/uart_tx_buffered_bitbang.sv
// Top level of the buffered 8N1 UART transmitter.
//
//   channel | direction | handshake             | beat payload
//   --------+-----------+-----------------------+--------------------------------
//   req     | in        | req_valid / req_ready | mode, data_byte, last_byte
//   rsp     | out       | rsp_valid / rsp_ready | tx_line, busy_res, status
//
// Each req beat's result lands in the rsp register at the accepting edge, and
// the next beat can be taken in the same cycle as the result leaves. The byte
// for a frame is read from the buffer RAM on the start-bit tick, so its
// registered read is ready for the first data tick.
// Reset is synchronous, active high: line high, idle, empty buffer; RAM
// contents are not cleared. A stalled rsp holds req_ready low.
module uart_tx_buffered_bitbang (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  utxbb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output utxbb_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   utxbb_pkg::dp_cmd_type  cmd;
   utxbb_pkg::dp_stat_type stat;

   // Sequencer: frame state (start, data, stop, gap) and beat handshake.
   utxbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_data.mode),
      .req_last  (req_data.last_byte),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: byte buffer RAM, length and read counters, bit counter,
   // line level and the rsp result register.
   utxbb_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_byte (req_data.data_byte),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> verif/uart_tx_buffered_bitbang_tb.sv
// Self-checking testbench for the buffered UART transmitter: random traffic, in-bench line model.
module uart_tx_buffered_bitbang_tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEM_GOAL = 1700;

   // Tracks the serial line, the message buffer and the transmit sequencer one
   // beat at a time, and keeps the responses still owed by the block.
   class uart_tx_scoreboard;
      logic                           line_level;
      logic                           sending;
      logic [3:0]                     frame_step;
      logic [3:0]                     bit_pos;
      logic [7:0]                     read_pos;
      logic [7:0]                     msg_len;
      logic [utxbb_pkg::BYTE_W-1:0]   byte_mem [utxbb_pkg::BUFFER_DEPTH];
      utxbb_pkg::rsp_type             line_state_q [$];
      int                             errors;
      int                             beats;
      int                             checked;
      int                             rejected;
      int                             dropped;
      int                             messages;

      function new();
         line_level = 1'b1;
         sending    = 1'b0;
         frame_step = '0;
         bit_pos    = '0;
         read_pos   = '0;
         msg_len    = '0;
         errors     = 0;
         beats      = 0;
         checked    = 0;
         rejected   = 0;
         dropped    = 0;
         messages   = 0;
      endfunction

      function int pending();
         return line_state_q.size();
      endfunction

      task report(string what);
         $display("ERROR @%0t: %s", $time, what);
         errors++;
      endtask

      // One bit period of the 8N1 frame: start, data LSB first, stop, gap.
      function void bit_period();
         logic [utxbb_pkg::BYTE_W-1:0] cur;
         if (!sending)
            return;
         if (frame_step == 0) begin
            line_level = 1'b0;
            bit_pos    = '0;
            frame_step = 4'd1;
         end else if (frame_step <= utxbb_pkg::DATA_BITS) begin
            cur = '0;
            if (read_pos < msg_len && read_pos < utxbb_pkg::BUFFER_DEPTH)
               cur = byte_mem[read_pos];
            line_level = cur[bit_pos[2:0]];
            frame_step = frame_step + 4'd1;
            bit_pos    = bit_pos + 4'd1;
         end else if (frame_step == utxbb_pkg::DATA_BITS + 1) begin
            line_level = 1'b1;
            frame_step = frame_step + 4'd1;
         end else begin
            // gap tick (and any stray step value) closes the byte
            frame_step = '0;
            read_pos   = read_pos + 8'd1;
            if (msg_len <= read_pos) begin
               sending  = 1'b0;
               msg_len  = '0;
               read_pos = '0;
            end
         end
      endfunction

      // Accepted request beat: update the line model and queue its response.
      function void take_request(utxbb_pkg::req_type r);
         utxbb_pkg::rsp_type    e;
         utxbb_pkg::status_type st;
         st = utxbb_pkg::STATUS_OK;
         beats++;
         if (r.mode) begin
            bit_period();
         end else if (sending) begin
            st = utxbb_pkg::STATUS_BUSY;
            rejected++;
         end else begin
            if (msg_len < utxbb_pkg::BUFFER_DEPTH) begin
               byte_mem[msg_len] = r.data_byte;
               msg_len = msg_len + 8'd1;
            end else begin
               st = utxbb_pkg::STATUS_FULL;
               dropped++;
            end
            if (r.last_byte && msg_len != 0) begin
               read_pos   = '0;
               frame_step = '0;
               bit_pos    = '0;
               sending    = 1'b1;
               messages++;
            end
         end
         e.tx_line  = line_level;
         e.busy_res = sending;
         e.status   = st;
         line_state_q.push_back(e);
      endfunction

      task check_result(utxbb_pkg::rsp_type got);
         utxbb_pkg::rsp_type e;
         if (line_state_q.size() == 0) begin
            report($sformatf("unexpected rsp beat tx_line=%0b busy=%0b status=%0d",
                             got.tx_line, got.busy_res, got.status));
            return;
         end
         e = line_state_q.pop_front();
         checked++;
         if (got.tx_line !== e.tx_line)
            report($sformatf("tx_line %0b, want %0b", got.tx_line, e.tx_line));
         if (got.busy_res !== e.busy_res)
            report($sformatf("busy_res %0b, want %0b", got.busy_res, e.busy_res));
         if (got.status !== e.status)
            report($sformatf("status %0d, want %0d", got.status, e.status));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   utxbb_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   utxbb_pkg::rsp_type rsp_data;

   uart_tx_scoreboard sb;
   int  cycles;
   int  counted;      // beats that do real work: loads into an idle block, ticks
   bit  quiet;        // no-idle stretch on both channels
   bit  full_done;

   uart_tx_buffered_bitbang u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a healthy run finishes far below this.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d responses outstanding", cycles, sb.pending());
         $display("uart_tx_buffered_bitbang: mismatch");
         $finish;
      end
   end

   // Response side: stall at random about 19 percent of the time, except in the quiet stretch.
   // Values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
      rsp_ready <= quiet || ($urandom_range(99) >= 19);
   end

   // Drive one request beat and wait for it to be taken. Valid stays high from
   // beat to beat unless a gap is inserted, so back-to-back beats are exercised.
   task send_item(logic mode, logic [utxbb_pkg::BYTE_W-1:0] data, logic last,
                  bit real_work);
      utxbb_pkg::req_type r;
      r.mode      = mode;
      r.data_byte = data;
      r.last_byte = last;
      if (!quiet && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!req_ready);
      sb.take_request(r);
      if (real_work)
         counted++;
   endtask

   // Tick with junk in the ignored fields.
   task tick_once();
      send_item(1'b1, utxbb_pkg::BYTE_W'($urandom), 1'($urandom), 1'b1);
   endtask

   // Hold the sender off until every owed response has come back.
   task hold_until_quiet();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   // Run the current message out, with an occasional load thrown at the busy block.
   task drain_message(int noise_pct);
      while (sb.sending) begin
         if ($urandom_range(99) < noise_pct)
            send_item(1'b0, utxbb_pkg::BYTE_W'($urandom), 1'($urandom), 1'b0);
         else
            tick_once();
      end
   endtask

   task send_message(int nbytes, int noise_pct);
      drain_message(0);
      for (int i = 0; i < nbytes; i++)
         send_item(1'b0, utxbb_pkg::BYTE_W'($urandom), 1'(i == nbytes - 1), 1'b1);
      drain_message(noise_pct);
   endtask

   // Fill the buffer, overflow it once without the last mark and once with it;
   // the marked overflow is dropped but still starts the full message.
   task overflow_buffer();
      drain_message(0);
      for (int i = 0; i < utxbb_pkg::BUFFER_DEPTH; i++)
         send_item(1'b0, utxbb_pkg::BYTE_W'($urandom), 1'b0, 1'b1);
      send_item(1'b0, utxbb_pkg::BYTE_W'($urandom), 1'b0, 1'b1);
      send_item(1'b0, utxbb_pkg::BYTE_W'($urandom), 1'b1, 1'b1);
      drain_message(2);
   endtask

   initial begin
      int r;
      sb        = new();
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      cycles    = 0;
      counted   = 0;
      quiet     = 1'b0;
      full_done = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: tick on an idle line, an all-ones byte with a load rejected
      // mid-frame, then an all-zeros byte with another rejected load; its end frees the buffer.
      tick_once();
      send_item(1'b0, 8'hFF, 1'b1, 1'b1);
      repeat (3) tick_once();
      send_item(1'b0, 8'h5A, 1'b1, 1'b0);
      drain_message(0);
      send_item(1'b0, 8'h00, 1'b1, 1'b1);
      repeat (5) tick_once();
      send_item(1'b0, 8'hC3, 1'b0, 1'b0);
      drain_message(0);

      // Sender pause: let the block run dry before the random traffic.
      hold_until_quiet();

      // Random: mostly well-formed messages with random bytes, some noise.
      // The no-idle stretch sits ahead of the long buffer overflow.
      while (counted < ITEM_GOAL) begin
         quiet <= (counted >= 150 && counted < 500);
         r = $urandom_range(99);
         if (!full_done && counted >= 600) begin
            overflow_buffer();
            full_done = 1'b1;
         end else if (r < 80) begin
            send_message(($urandom_range(9) == 0) ? $urandom_range(6, 16)
                                                  : $urandom_range(1, 3), 8);
         end else if (r < 96) begin
            repeat ($urandom_range(1, 4))
               send_item(1'($urandom), utxbb_pkg::BYTE_W'($urandom), 1'($urandom), 1'b0);
         end else begin
            hold_until_quiet();
         end
      end
      drain_message(0);
      quiet <= 1'b0;
      req_valid <= 1'b0;

      // Wait out the owed responses, then idle for DRAIN_CYCLES to catch strays.
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (sb.pending() != 0)
         sb.check_result(~sb.line_state_q[0]);

      $display("Covered %0d request beats, %0d messages sent, %0d responses compared.",
               sb.beats, sb.messages, sb.checked);
      $display("Loads refused while busy: %0d, bytes dropped on a full buffer: %0d.",
               sb.rejected, sb.dropped);
      if (sb.errors == 0)
         $display("uart_tx_buffered_bitbang: match");
      else
         $display("uart_tx_buffered_bitbang: mismatch");
      $finish;
   end

endmodule
